@@ design/iqpm_pkg.sv @@
package iqpm_pkg;

   // sample and accumulator sizes
   localparam int SAMPLE_WIDTH = 16;
   localparam int SUM_WIDTH    = 50;
   localparam int DB_WIDTH     = 16;

   // power units: I*I + Q*Q carries 2^-SCALE_EXP per LSB
   localparam int SCALE_EXP    = 2 * (SAMPLE_WIDTH - 1);

   // log2 mantissa held as Q30 in [2^30, 2^31)
   localparam int MANT_WIDTH   = 31;
   localparam int MANT_TOP     = MANT_WIDTH - 1;
   localparam int FRAC_BITS    = 16;

   // step counter covers the divider bit position and the log iterations
   localparam int STEP_WIDTH   = 6;

   localparam int BLOCK_LENGTH_RESET = 192000;

   // 10*log10(2) in Q16, and 3 dB in 1/256 dB
   localparam logic signed [18:0] DB_PER_LOG2 = 19'sd197283;
   localparam int                 OFFSET_3DB  = 768;
   localparam int                 ROUND_SHIFT = 24;

   localparam logic signed [DB_WIDTH-1:0] DB_MIN = {1'b1, {(DB_WIDTH-1){1'b0}}};
   localparam logic signed [DB_WIDTH-1:0] DB_MAX = {1'b0, {(DB_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] i_sample;
      logic signed [SAMPLE_WIDTH-1:0] q_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] i_out;
      logic signed [SAMPLE_WIDTH-1:0] q_out;
      logic                           block_last;
      logic signed [DB_WIDTH-1:0]     power_dbfs;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_NORM,
      ST_LOG,
      ST_SCALE,
      ST_ROUND,
      ST_EMIT
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic accum;
      logic div_step;
      logic norm;
      logic log_step;
      logic scale;
      logic round;
      logic emit;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_last;
      logic step_zero;
      logic out_free;
   } status_type;

endpackage

@@ design/iqpm_ctrl.sv @@
module iqpm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  iqpm_pkg::status_type   status,
   output iqpm_pkg::cmd_type      cmd
);

   iqpm_pkg::state_type state_ff;
   iqpm_pkg::state_type state_in;

   // hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iqpm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequence one sample through the datapath
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         iqpm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = iqpm_pkg::ST_ACCUM;
            end
         end
         iqpm_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (status.is_last) begin
               state_in = iqpm_pkg::ST_DIVIDE;
            end else begin
               state_in = iqpm_pkg::ST_EMIT;
            end
         end
         iqpm_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.step_zero) begin
               state_in = iqpm_pkg::ST_NORM;
            end
         end
         iqpm_pkg::ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = iqpm_pkg::ST_LOG;
         end
         iqpm_pkg::ST_LOG: begin
            cmd.log_step = 1'b1;
            if (status.step_zero) begin
               state_in = iqpm_pkg::ST_SCALE;
            end
         end
         iqpm_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = iqpm_pkg::ST_ROUND;
         end
         iqpm_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = iqpm_pkg::ST_EMIT;
         end
         iqpm_pkg::ST_EMIT: begin
            // wait for the output register to free up
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = iqpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = iqpm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/iqpm_dp.sv @@
module iqpm_dp #(
   parameter int COUNT_WIDTH = 19
) (
   input  logic                     clock,
   input  logic                     reset,
   input  iqpm_pkg::req_type        req_data,
   input  logic                     csr_valid,
   input  logic [COUNT_WIDTH-1:0]   csr_wdata,
   input  iqpm_pkg::cmd_type        cmd,
   output iqpm_pkg::status_type     status,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output iqpm_pkg::rsp_type        rsp_data
);

   localparam int SW = iqpm_pkg::SUM_WIDTH;
   localparam int MW = iqpm_pkg::MANT_WIDTH;
   localparam int FB = iqpm_pkg::FRAC_BITS;
   localparam int DW = iqpm_pkg::DB_WIDTH;
   localparam int XW = 7;               // signed exponent
   localparam int LW = XW + FB;         // signed log2 in Q16
   localparam int PW = LW + 19;         // dB product
   localparam int RW = PW - iqpm_pkg::ROUND_SHIFT;

   // architectural state
   logic [COUNT_WIDTH-1:0]  len_ff, len_in;
   logic [SW-1:0]           sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic signed [DW-1:0]    last_power_ff, last_power_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // working registers
   iqpm_pkg::req_type                 samp_ff, samp_in;
   logic                              last_flag_ff, last_flag_in;
   logic [SW-1:0]                     dividend_ff, dividend_in;
   logic [COUNT_WIDTH-1:0]            rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0]            divisor_ff, divisor_in;
   logic [iqpm_pkg::STEP_WIDTH-1:0]   step_ff, step_in;
   logic [iqpm_pkg::STEP_WIDTH-1:0]   e_ff, e_in;
   logic                              found_ff, found_in;
   logic [MW-1:0]                     mant_ff, mant_in;
   logic [FB-1:0]                     frac_ff, frac_in;
   logic signed [PW-1:0]              db_ff, db_in;
   iqpm_pkg::rsp_type                 rsp_ff, rsp_in;

   // combinational helpers
   logic signed [2*iqpm_pkg::SAMPLE_WIDTH-1:0] i_sq, q_sq;
   logic [2*iqpm_pkg::SAMPLE_WIDTH:0]          norm;
   logic [SW-1:0]                              sum_next;
   logic [COUNT_WIDTH-1:0]                     len_eff;
   logic [COUNT_WIDTH:0]                       count_inc;
   logic                                       is_last;
   logic [COUNT_WIDTH:0]                       rem_sh, rem_diff;
   logic                                       qbit;
   logic [4:0]                                 norm_shamt;
   logic [2*MW-1:0]                            prod;
   logic [MW:0]                                prod_q30;
   logic signed [XW-1:0]                       exp_s;
   logic signed [LW-1:0]                       l_val;
   logic signed [PW-1:0]                       db_bias;
   logic signed [RW-1:0]                       db_rnd;
   logic signed [RW:0]                         db_off;
   logic signed [DW-1:0]                       db_sat;
   logic                                       out_free;

   // sample power and block end test
   always_comb begin
      i_sq      = samp_ff.i_sample * samp_ff.i_sample;
      q_sq      = samp_ff.q_sample * samp_ff.q_sample;
      norm      = {1'b0, i_sq} + {1'b0, q_sq};
      sum_next  = sum_ff + SW'(norm);
      len_eff   = (len_ff == '0) ? COUNT_WIDTH'(1) : len_ff;
      count_inc = {1'b0, count_ff} + (COUNT_WIDTH + 1)'(1);
      is_last   = count_inc >= {1'b0, len_eff};
   end

   // restoring divide step, one quotient bit
   always_comb begin
      rem_sh   = {rem_ff, dividend_ff[SW-1]};
      rem_diff = rem_sh - {1'b0, divisor_ff};
      qbit     = rem_sh >= {1'b0, divisor_ff};
   end

   // log2 squaring step and dB scaling
   always_comb begin
      norm_shamt = 5'(6'(iqpm_pkg::MANT_TOP) - e_ff);
      prod       = mant_ff * mant_ff;
      prod_q30   = prod[2*MW-1:MW-1];
      exp_s      = XW'(e_ff) - XW'(iqpm_pkg::SCALE_EXP);
      l_val      = {exp_s, frac_ff};
      db_bias    = db_ff + (PW'(1) <<< (iqpm_pkg::ROUND_SHIFT - 1));
      db_rnd     = db_bias[PW-1:iqpm_pkg::ROUND_SHIFT];
      db_off     = (RW + 1)'(db_rnd) - (RW + 1)'(iqpm_pkg::OFFSET_3DB);
      if (db_off < (RW + 1)'(iqpm_pkg::DB_MIN)) begin
         db_sat = iqpm_pkg::DB_MIN;
      end else if (db_off > (RW + 1)'(iqpm_pkg::DB_MAX)) begin
         db_sat = iqpm_pkg::DB_MAX;
      end else begin
         db_sat = db_off[DW-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next values of all registers
   always_comb begin
      len_in        = len_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      last_power_in = last_power_ff;
      samp_in       = samp_ff;
      last_flag_in  = last_flag_ff;
      dividend_in   = dividend_ff;
      rem_in        = rem_ff;
      divisor_in    = divisor_ff;
      step_in       = step_ff;
      e_in          = e_ff;
      found_in      = found_ff;
      mant_in       = mant_ff;
      frac_in       = frac_ff;
      db_in         = db_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (csr_valid) begin
         len_in = csr_wdata;
      end

      // capture the beat
      if (cmd.load) begin
         samp_in = req_data;
      end

      // accumulate; on block end start the divider and clear the block
      if (cmd.accum) begin
         last_flag_in = is_last;
         if (is_last) begin
            sum_in      = '0;
            count_in    = '0;
            dividend_in = sum_next;
            divisor_in  = len_eff;
            rem_in      = '0;
            step_in     = iqpm_pkg::STEP_WIDTH'(SW - 1);
            found_in    = 1'b0;
            mant_in     = '0;
            e_in        = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_inc[COUNT_WIDTH-1:0];
         end
      end

      // one quotient bit; gather the mantissa from the leading one down
      if (cmd.div_step) begin
         dividend_in = dividend_ff << 1;
         rem_in      = qbit ? rem_diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
         step_in     = step_ff - iqpm_pkg::STEP_WIDTH'(1);
         if (!found_ff && qbit) begin
            found_in = 1'b1;
            e_in     = step_ff;
            mant_in  = MW'(1);
         end else if (found_ff && !mant_ff[iqpm_pkg::MANT_TOP]) begin
            mant_in = {mant_ff[MW-2:0], qbit};
         end
      end

      // align short quotients to Q30
      if (cmd.norm) begin
         if (found_ff && (e_ff < iqpm_pkg::STEP_WIDTH'(iqpm_pkg::MANT_TOP))) begin
            mant_in = mant_ff << norm_shamt;
         end
         step_in = iqpm_pkg::STEP_WIDTH'(FB - 1);
         frac_in = '0;
      end

      // square and take one fraction bit
      if (cmd.log_step) begin
         step_in = step_ff - iqpm_pkg::STEP_WIDTH'(1);
         if (prod_q30[MW]) begin
            mant_in = prod_q30[MW:1];
            frac_in = {frac_ff[FB-2:0], 1'b1};
         end else begin
            mant_in = prod_q30[MW-1:0];
            frac_in = {frac_ff[FB-2:0], 1'b0};
         end
      end

      if (cmd.scale) begin
         db_in = l_val * iqpm_pkg::DB_PER_LOG2;
      end

      // round, drop 3 dB, saturate; a zero mean reads as the floor
      if (cmd.round) begin
         last_power_in = found_ff ? db_sat : iqpm_pkg::DB_MIN;
      end

      if (cmd.emit) begin
         rsp_in.i_out      = samp_ff.i_sample;
         rsp_in.q_out      = samp_ff.q_sample;
         rsp_in.block_last = last_flag_ff;
         rsp_in.power_dbfs = last_power_ff;
         rsp_valid_in      = 1'b1;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= COUNT_WIDTH'(iqpm_pkg::BLOCK_LENGTH_RESET);
         sum_ff        <= '0;
         count_ff      <= '0;
         last_power_ff <= iqpm_pkg::DB_MIN;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         sum_ff        <= sum_in;
         count_ff      <= count_in;
         last_power_ff <= last_power_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      samp_ff      <= samp_in;
      last_flag_ff <= last_flag_in;
      dividend_ff  <= dividend_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      step_ff      <= step_in;
      e_ff         <= e_in;
      found_ff     <= found_in;
      mant_ff      <= mant_in;
      frac_ff      <= frac_in;
      db_ff        <= db_in;
      rsp_ff       <= rsp_in;
   end

   assign status.is_last   = is_last;
   assign status.step_zero = step_ff == '0;
   assign status.out_free  = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/iq_block_power_dbfs_meter.sv @@
// channel | direction | handshake           | beat
// req     | in        | req_valid/req_stall | iqpm_pkg::req_type (i_sample, q_sample)
// rsp     | out       | rsp_valid/rsp_stall | iqpm_pkg::rsp_type (i_out, q_out,
//         |           |                     |   block_last, power_dbfs)
// csr     | in        | csr_valid/csr_ready | block_length, COUNT_WIDTH bits
//
// A sample that does not end a block is accepted, accumulated and loaded into the
// output register. A block-ending sample also runs a 50-step restoring divider
// (one quotient bit a cycle), 16 log2 squaring steps, plus normalize, scale and round.
// Reset is synchronous: it clears the sum, the count, the reported power (to the
// floor), the output valid and the controller; block_length returns to 192000.
// Under rsp_stall the result holds; the next sample is worked on, then waits to emit.
module iq_block_power_dbfs_meter #(
   parameter int COUNT_WIDTH = 19
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  iqpm_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output iqpm_pkg::rsp_type        rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [COUNT_WIDTH-1:0]   csr_wdata
);

   iqpm_pkg::cmd_type    ctrl_cmd;
   iqpm_pkg::status_type dp_status;

   // take register writes at any time
   assign csr_ready = 1'b1;

   iqpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   iqpm_dp #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .cmd       (ctrl_cmd),
      .status    (dp_status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // one beat in flight: busy right after an accept
   a_busy_after_accept : assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall
   ) else $error("input accepted again before the previous sample finished");

   // the controller issues at most one datapath command per cycle
   a_cmd_onehot : assert property (
      @(posedge clock) disable iff (reset)
      $onehot0(ctrl_cmd)
   ) else $error("more than one datapath command at once");

   // a new result only comes out of work on an accepted sample
   a_result_from_work : assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall)
   ) else $error("result appeared while the block was idle");

endmodule

@@ dv/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CNT_W          = 19;
   localparam int CSR_SETTLE     = 80;    // outlasts the work on a block-ending sample
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 1450;
   localparam int IDLE_PCT       = 18;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   iqpm_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   iqpm_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_wdata = '0;

   // sample source and result scoreboard
   iqpm_pkg::req_type sample_queue[$];
   iqpm_pkg::rsp_type expected_samples[$];

   // shadow of the meter state
   bit [CNT_W-1:0] block_len;
   bit [49:0]      power_sum;
   bit [CNT_W-1:0] samples_in_block;
   logic signed [iqpm_pkg::DB_WIDTH-1:0] last_dbfs;

   int  beats_queued   = 0;
   int  beats_taken    = 0;
   int  csr_writes     = 0;
   int  blocks_done    = 0;
   int  floor_blocks   = 0;
   int  mismatches     = 0;
   int  stall_cycles   = 0;
   bit  no_idle        = 1'b0;
   logic req_accepted  = 1'b0;

   iq_block_power_dbfs_meter #(.COUNT_WIDTH(CNT_W)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // block mean (units of 2^-SCALE_EXP) to dBFS in 1/256 dB
   function automatic logic signed [iqpm_pkg::DB_WIDTH-1:0] dbfs_of_mean(bit [63:0] mean);
      bit [63:0] m;
      bit [15:0] frac;
      int        e;
      longint    l, d, r;
      if (mean == 0)
         return iqpm_pkg::DB_MIN;
      e = 63;
      while (mean[e] == 1'b0)
         e--;
      m = (e > iqpm_pkg::MANT_TOP) ? (mean >> (e - iqpm_pkg::MANT_TOP))
                                   : (mean << (iqpm_pkg::MANT_TOP - e));
      frac = '0;
      // square-and-compare log2, one fraction bit per step
      for (int k = 0; k < iqpm_pkg::FRAC_BITS; k++) begin
         m = (m * m) >> iqpm_pkg::MANT_TOP;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      l = longint'(e) * 65536 + longint'(frac)
          - longint'(iqpm_pkg::SCALE_EXP) * 65536;
      d = l * longint'(iqpm_pkg::DB_PER_LOG2);
      r = (d + (64'sd1 <<< (iqpm_pkg::ROUND_SHIFT - 1))) >>> iqpm_pkg::ROUND_SHIFT;
      r = r - iqpm_pkg::OFFSET_3DB;
      if (r < longint'(iqpm_pkg::DB_MIN))
         r = longint'(iqpm_pkg::DB_MIN);
      if (r > longint'(iqpm_pkg::DB_MAX))
         r = longint'(iqpm_pkg::DB_MAX);
      return r[iqpm_pkg::DB_WIDTH-1:0];
   endfunction

   // accumulate one sample and form the result beat it produces
   function automatic iqpm_pkg::rsp_type meter_sample(iqpm_pkg::req_type beat);
      iqpm_pkg::rsp_type r;
      longint            iv, qv;
      bit [63:0]         len;
      iv = beat.i_sample;
      qv = beat.q_sample;
      power_sum = power_sum + 50'(iv * iv + qv * qv);
      len = (block_len == 0) ? 64'd1 : 64'(block_len);
      r.block_last = 1'b0;
      if (64'(samples_in_block) + 1 >= len) begin
         last_dbfs = dbfs_of_mean(64'(power_sum) / len);
         power_sum = '0;
         samples_in_block = '0;
         r.block_last = 1'b1;
      end else begin
         samples_in_block = samples_in_block + 1'b1;
      end
      r.i_out = beat.i_sample;
      r.q_out = beat.q_sample;
      r.power_dbfs = last_dbfs;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // sender: advance to the next beat once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (sample_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_data  <= sample_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall at random unless the no-idle stretch is on
   always @(negedge clock) begin
      rsp_stall <= !reset && !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // monitor: track register writes, predict accepted samples, check results
   always @(posedge clock) begin
      iqpm_pkg::rsp_type want;
      if (reset) begin
         block_len        = CNT_W'(iqpm_pkg::BLOCK_LENGTH_RESET);
         power_sum        = '0;
         samples_in_block = '0;
         last_dbfs        = iqpm_pkg::DB_MIN;
         req_accepted    <= 1'b0;
      end else begin
         req_accepted <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            block_len = csr_wdata;
            csr_writes++;
         end
         if (req_valid && !req_stall) begin
            expected_samples = {expected_samples, meter_sample(req_data)};
            beats_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected result beat", 1, 0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_data.i_out !== want.i_out)
                  report_mismatch("i_out", rsp_data.i_out, want.i_out);
               if (rsp_data.q_out !== want.q_out)
                  report_mismatch("q_out", rsp_data.q_out, want.q_out);
               if (rsp_data.block_last !== want.block_last)
                  report_mismatch("block_last", rsp_data.block_last, want.block_last);
               if (rsp_data.power_dbfs !== want.power_dbfs)
                  report_mismatch("power_dbfs", rsp_data.power_dbfs, want.power_dbfs);
               if (want.block_last) begin
                  blocks_done++;
                  if (want.power_dbfs == iqpm_pkg::DB_MIN)
                     floor_blocks++;
               end
            end
         end
      end
   end

   // watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAIL iq_block_power_dbfs_meter");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic push_sample(logic signed [iqpm_pkg::SAMPLE_WIDTH-1:0] i,
                              logic signed [iqpm_pkg::SAMPLE_WIDTH-1:0] q);
      iqpm_pkg::req_type beat;
      beat.i_sample = i;
      beat.q_sample = q;
      sample_queue = {sample_queue, beat};
      beats_queued++;
   endtask

   // hold until every queued sample is taken and every result has come back
   task automatic wait_drained();
      do
         @(negedge clock);
      while (beats_taken != beats_queued || expected_samples.size() != 0);
   endtask

   task automatic write_block_length(bit [CNT_W-1:0] value);
      int seen;
      wait_drained();
      repeat (CSR_SETTLE) @(negedge clock);
      seen = csr_writes;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do
         @(negedge clock);
      while (csr_writes == seen);
      csr_valid <= 1'b0;
   endtask

   // sample content: zero, tiny, full-scale corners or anything
   function automatic logic signed [iqpm_pkg::SAMPLE_WIDTH-1:0] pick_sample(int mode);
      if (mode == 0)
         return '0;
      if (mode == 1)
         return 16'($urandom_range(0, 4) - 2);
      if (mode == 2)
         return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return '0;
         3: return 16'($urandom_range(0, 16) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int          sent;
      int          phase;
      int          count;
      int          mode;
      bit [CNT_W-1:0] len;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: corners at the reset block length, power stays at the floor
      push_sample(16'sh7fff, 16'sh8000);
      push_sample(16'sh8000, 16'sh7fff);
      push_sample(16'sh0000, 16'sh0000);
      push_sample(-16'sd1, 16'sd1);
      push_sample(16'sd1, -16'sd1);

      // longest block, then shorten it mid-block so the next sample ends it
      write_block_length({CNT_W{1'b1}});
      repeat (4) push_sample(16'sh8000, 16'sh8000);
      write_block_length(2);
      push_sample(16'sh7fff, 16'sh7fff);
      push_sample(16'sh0000, 16'sh0000);
      push_sample(16'sh0000, 16'sh0000);

      // zero length acts as one: every sample ends a block
      write_block_length(0);
      push_sample(16'sd1, 16'sd0);
      push_sample(16'sh8000, 16'sh8000);
      push_sample(16'sd0, -16'sd1);
      write_block_length(1);
      push_sample(16'sh7fff, 16'sh8000);
      push_sample(-16'sd1, -16'sd1);
      write_block_length(3);
      repeat (3) push_sample(16'sh0000, 16'sh0000);

      // random phases with a fresh block length each
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: len = 0;
            1: len = 1;
            2: len = 2;
            3: len = 3;
            4, 5: len = CNT_W'($urandom_range(4, 16));
            6, 7: len = CNT_W'($urandom_range(17, 80));
            8: len = CNT_W'($urandom_range(81, 300));
            default: len = CNT_W'({CNT_W{1'b1}} - $urandom_range(0, 3));
         endcase
         write_block_length(len);
         if (len > 300)
            count = $urandom_range(5, 20);
         else
            count = $urandom_range(1, 4) * ((len == 0) ? 1 : len) + $urandom_range(0, len);
         if (count > 300)
            count = 300;
         // keep the no-idle stretch long
         if (phase == 3)
            count = 250;
         mode = $urandom_range(0, 9);
         no_idle = (phase == 3);
         for (int n = 0; n < count; n++) begin
            // pause the sender halfway until the meter has caught up
            if (phase == 5 && n == count / 2)
               wait_drained();
            push_sample(pick_sample(mode), pick_sample(mode));
         end
         sent += count;
         phase++;
      end

      wait_drained();
      no_idle = 1'b0;
      repeat (CSR_SETTLE) @(negedge clock);

      $display("ran %0d samples over %0d block length writes", beats_queued, csr_writes);
      $display("checked %0d finished blocks, %0d of them at the power floor",
               blocks_done, floor_blocks);
      if (mismatches == 0) begin
         $display("PASS iq_block_power_dbfs_meter");
      end else begin
         $display("FAIL iq_block_power_dbfs_meter");
      end
      $finish;
   end

endmodule
